>>> sv/rff_pkg.sv
// ----------------------------------------------------------------------------
// rff_pkg: shared types and constants for the raster flood fill core
// Operation codes, field widths, default grid size and the command/status
// bundles between the fill controller and the datapath.
// ----------------------------------------------------------------------------
package rff_pkg;

  localparam int unsigned GRID_WIDTH_DEF  = 64;
  localparam int unsigned GRID_HEIGHT_DEF = 64;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned COORD_W = 6;
  localparam int unsigned COLOR_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_FILL  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    logic load;
    logic item_wr;
    logic item_rd;
    logic seed_push;
    logic pop;
    logic cell_rd;
    logic paint;
    logic nb_push;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic op_write;
    logic op_fill;
    logic op_read;
    logic on_grid;
    logic same_color;
    logic stack_empty;
    logic cell_match;
    logic nb_last;
    logic out_busy;
  } status_t;

endpackage

>>> sv/rff_if.sv
// ----------------------------------------------------------------------------
// rff_if: request and result channels of the raster flood fill core
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface rff_in_if;
  import rff_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] y;
  logic [COLOR_W-1:0] target_color;
  logic [COLOR_W-1:0] new_color;

  modport source (output valid, op, x, y, target_color, new_color, input ready);
  modport sink   (input valid, op, x, y, target_color, new_color, output ready);
endinterface

interface rff_out_if;
  import rff_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] read_color;
  logic               fill_skipped;

  modport source (output valid, read_color, fill_skipped, input ready);
  modport sink   (input valid, read_color, fill_skipped, output ready);
endinterface

>>> sv/rff_ctrl.sv
// ----------------------------------------------------------------------------
// rff_ctrl: sequencer of the raster flood fill core
// Decodes each request and steps the fill loop: pop, fetch pixel, compare,
// paint and push those of the four neighbors that lie on the grid.
// ----------------------------------------------------------------------------
module rff_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rff_pkg::status_t status_i,
  output rff_pkg::cmd_t   cmd_o
);
  import rff_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ_WAIT,
    S_POP,
    S_POP_WAIT,
    S_CHECK,
    S_PUSH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = !status_i.out_busy;
        if (in_valid_i && !status_i.out_busy) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status_i.op_read) begin
          cmd_o.item_rd = 1'b1;
          state_d       = S_READ_WAIT;
        end else if (status_i.op_fill && !status_i.same_color && status_i.on_grid) begin
          cmd_o.seed_push = 1'b1;
          state_d         = S_POP;
        end else begin
          cmd_o.item_wr  = status_i.op_write;
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_READ_WAIT: begin
        cmd_o.out_load = 1'b1;
        state_d        = S_IDLE;
      end
      S_POP: begin
        if (status_i.stack_empty) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cmd_o.cell_rd = 1'b1;
        state_d       = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.cell_match) begin
          cmd_o.paint = 1'b1;
          state_d     = S_PUSH;
        end else begin
          state_d = S_POP;
        end
      end
      S_PUSH: begin
        cmd_o.nb_push = 1'b1;
        if (status_i.nb_last) begin
          state_d = S_POP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/rff_datapath.sv
// ----------------------------------------------------------------------------
// rff_datapath: frame store, coordinate stack and result register
// Holds the request, the pixel memory, the LIFO of pending cells, the
// neighbor generator and the output register.
// ----------------------------------------------------------------------------
module rff_datapath #(
  parameter int unsigned GRID_WIDTH  = rff_pkg::GRID_WIDTH_DEF,
  parameter int unsigned GRID_HEIGHT = rff_pkg::GRID_HEIGHT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [rff_pkg::OP_W-1:0]     op_i,
  input  logic [rff_pkg::COORD_W-1:0]  x_i,
  input  logic [rff_pkg::COORD_W-1:0]  y_i,
  input  logic [rff_pkg::COLOR_W-1:0]  target_color_i,
  input  logic [rff_pkg::COLOR_W-1:0]  new_color_i,
  input  rff_pkg::cmd_t                cmd_i,
  output rff_pkg::status_t             status_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [rff_pkg::COLOR_W-1:0]  read_color_o,
  output logic                         fill_skipped_o
);
  import rff_pkg::*;

  localparam int unsigned XW         = $clog2(GRID_WIDTH);
  localparam int unsigned YW         = $clog2(GRID_HEIGHT);
  localparam int unsigned EW         = XW + YW;
  localparam int unsigned CellCount  = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned AW         = $clog2(CellCount);
  localparam int unsigned StackDepth = 4 * CellCount + 1;
  localparam int unsigned SIW        = $clog2(StackDepth);
  localparam int unsigned SPW        = $clog2(StackDepth + 1);
  localparam int unsigned CW         = 13;
  localparam logic [1:0]  NbLast     = 2'd3;

  function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] cx,
                                            input logic [YW-1:0] cy);
    logic [AW-1:0] a;
    a = AW'(cy) * AW'(GRID_WIDTH) + AW'(cx);
    return a;
  endfunction

  // request
  logic [OP_W-1:0]    op_q;
  logic [XW-1:0]      item_x_q;
  logic [YW-1:0]      item_y_q;
  logic               on_grid_q;
  logic [COLOR_W-1:0] target_q;
  logic [COLOR_W-1:0] paint_q;

  // fill state
  logic [COLOR_W-1:0] frame_mem [CellCount];
  logic [COLOR_W-1:0] frame_rdata_q;
  logic [EW-1:0]      stack_mem [StackDepth];
  logic [EW-1:0]      stack_rdata_q;
  logic [SPW-1:0]     top_q;
  logic [XW-1:0]      cur_x_q;
  logic [YW-1:0]      cur_y_q;
  logic [1:0]         nb_q;

  // result
  logic               out_valid_q;
  logic [COLOR_W-1:0] read_color_q;
  logic               fill_skipped_q;

  logic [AW-1:0]      frame_addr;
  logic               frame_we;
  logic               frame_re;
  logic               nb_ok;
  logic [EW-1:0]      nb_entry;
  logic               stack_we;
  logic [EW-1:0]      stack_wdata;
  logic [SPW-1:0]     top_dec;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= op_i;
      item_x_q  <= XW'(x_i);
      item_y_q  <= YW'(y_i);
      on_grid_q <= (CW'(x_i) < CW'(GRID_WIDTH)) && (CW'(y_i) < CW'(GRID_HEIGHT));
      target_q  <= target_color_i;
      paint_q   <= new_color_i;
    end
  end

  always_comb begin
    if (cmd_i.cell_rd) begin
      frame_addr = addr_of(stack_rdata_q[XW-1:0], stack_rdata_q[EW-1:XW]);
    end else if (cmd_i.paint) begin
      frame_addr = addr_of(cur_x_q, cur_y_q);
    end else begin
      frame_addr = addr_of(item_x_q, item_y_q);
    end
  end

  assign frame_we = (cmd_i.item_wr && on_grid_q) || cmd_i.paint;
  assign frame_re = cmd_i.item_rd || cmd_i.cell_rd;

  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_mem[frame_addr] <= paint_q;
    end
    if (frame_re) begin
      frame_rdata_q <= frame_mem[frame_addr];
    end
  end

  // neighbors in order x+1, x-1, y+1, y-1
  always_comb begin
    case (nb_q)
      2'd0: begin
        nb_ok    = cur_x_q != XW'(GRID_WIDTH - 1);
        nb_entry = {cur_y_q, cur_x_q + XW'(1)};
      end
      2'd1: begin
        nb_ok    = cur_x_q != '0;
        nb_entry = {cur_y_q, cur_x_q - XW'(1)};
      end
      2'd2: begin
        nb_ok    = cur_y_q != YW'(GRID_HEIGHT - 1);
        nb_entry = {cur_y_q + YW'(1), cur_x_q};
      end
      default: begin
        nb_ok    = cur_y_q != '0;
        nb_entry = {cur_y_q - YW'(1), cur_x_q};
      end
    endcase
  end

  assign stack_we    = cmd_i.seed_push || (cmd_i.nb_push && nb_ok);
  assign stack_wdata = cmd_i.seed_push ? {item_y_q, item_x_q} : nb_entry;
  assign top_dec     = top_q - SPW'(1);

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[top_q[SIW-1:0]] <= stack_wdata;
    end
    if (cmd_i.pop) begin
      stack_rdata_q <= stack_mem[top_dec[SIW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cell_rd) begin
      cur_x_q <= stack_rdata_q[XW-1:0];
      cur_y_q <= stack_rdata_q[EW-1:XW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= '0;
      nb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (stack_we) begin
        top_q <= top_q + SPW'(1);
      end else if (cmd_i.pop) begin
        top_q <= top_dec;
      end
      if (cmd_i.paint) begin
        nb_q <= '0;
      end else if (cmd_i.nb_push) begin
        nb_q <= nb_q + 2'd1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      read_color_q   <= (op_q == OP_READ && on_grid_q) ? frame_rdata_q : '0;
      fill_skipped_q <= (op_q == OP_FILL) && (target_q == paint_q);
    end
  end

  assign status_o.op_write    = op_q == OP_WRITE;
  assign status_o.op_fill     = op_q == OP_FILL;
  assign status_o.op_read     = op_q == OP_READ;
  assign status_o.on_grid     = on_grid_q;
  assign status_o.same_color  = target_q == paint_q;
  assign status_o.stack_empty = top_q == '0;
  assign status_o.cell_match  = frame_rdata_q == target_q;
  assign status_o.nb_last     = nb_q == NbLast;
  assign status_o.out_busy    = out_valid_q;

  assign out_valid_o    = out_valid_q;
  assign read_color_o   = read_color_q;
  assign fill_skipped_o = fill_skipped_q;

`ifndef NO_ASSERTIONS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stack_we |-> top_q != SPW'(StackDepth))
    else $error("stack push beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> top_q != '0)
    else $error("stack pop while empty");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !out_valid_q)
    else $error("result register overwritten");

  a_paint_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.paint |-> frame_rdata_q == target_q)
    else $error("painted a pixel that is not the target color");

  a_fill_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> top_q == '0)
    else $error("result issued with entries left on the stack");
`endif

endmodule

>>> sv/raster_flood_fill_core.sv
// ----------------------------------------------------------------------------
// raster_flood_fill_core: frame store with a 4-connected flood fill
// Requests arrive on in_i, one result per request leaves on out_o.
//
// A request is a write (0), a fill (1) or a read (2) at (x, y). A write
// stores new_color, a read returns the pixel in read_color, a fill
// recolors the 4-connected region equal to target_color, using a
// coordinate stack in block memory. fill_skipped is set when a fill has
// target_color equal to new_color.
// A fill that is neither skipped nor off-grid walks the coordinate stack, so
// its time grows with the painted area. One request is in flight at a time:
// in_i.ready is high only while the sequencer is idle and the result register
// is empty, so a stalled result holds off the next request. Reset clears the
// sequencer, stack pointer and result valid; pixel memory is undefined until
// written.
// ----------------------------------------------------------------------------
module raster_flood_fill_core #(
  parameter int unsigned GRID_WIDTH  = rff_pkg::GRID_WIDTH_DEF,
  parameter int unsigned GRID_HEIGHT = rff_pkg::GRID_HEIGHT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rff_in_if.sink    in_i,
  rff_out_if.source out_o
);
  import rff_pkg::*;

  cmd_t    cmd;
  status_t status;

  rff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rff_datapath #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (in_i.op),
    .x_i            (in_i.x),
    .y_i            (in_i.y),
    .target_color_i (in_i.target_color),
    .new_color_i    (in_i.new_color),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .read_color_o   (out_o.read_color),
    .fill_skipped_o (out_o.fill_skipped)
  );

endmodule

>>> sim/raster_fill_checker.sv
// ----------------------------------------------------------------------------
// raster_fill_checker: result checker for the raster flood fill core
// Watches the request and result channels. It keeps its own copy of the frame
// store, works out the result of every accepted request, and compares each
// result field by field with the oldest one that is still waiting.
// ----------------------------------------------------------------------------
module raster_fill_checker #(
  parameter int unsigned GRID_W = rff_pkg::GRID_WIDTH_DEF,
  parameter int unsigned GRID_H = rff_pkg::GRID_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rff_in_if           req_mon,
  rff_out_if          rsp_mon,
  output int unsigned mismatch_o,
  output int unsigned pending_o,
  output int unsigned painted_o
);
  import rff_pkg::*;

  typedef struct packed {
    logic [COLOR_W-1:0] read_color;
    logic               fill_skipped;
  } fill_result_t;

  logic [COLOR_W-1:0] pixels [GRID_W*GRID_H];
  fill_result_t       result_q [$];
  int unsigned        mismatches = 0;
  int unsigned        waiting    = 0;
  int unsigned        painted    = 0;

  assign mismatch_o = mismatches;
  assign pending_o  = waiting;
  assign painted_o  = painted;

  function automatic bit on_grid(int unsigned x, int unsigned y);
    return (x < GRID_W) && (y < GRID_H);
  endfunction

  function automatic bit still_target(int unsigned x, int unsigned y, logic [COLOR_W-1:0] tgt);
    return on_grid(x, y) && (pixels[y * GRID_W + x] == tgt);
  endfunction

  // LIFO walk, neighbors pushed right, left, down, up
  function automatic void flood_region(int unsigned sx, int unsigned sy,
                                       logic [COLOR_W-1:0] tgt, logic [COLOR_W-1:0] paint);
    int unsigned pend [$];
    int unsigned idx;
    int unsigned cx;
    int unsigned cy;
    if (!on_grid(sx, sy)) return;
    pend.push_back(sy * GRID_W + sx);
    while (pend.size() != 0) begin
      idx = pend.pop_back();
      cx  = idx % GRID_W;
      cy  = idx / GRID_W;
      if (pixels[idx] != tgt) continue;
      pixels[idx] = paint;
      painted++;
      if (still_target(cx + 1, cy, tgt)) pend.push_back(idx + 1);
      if (cx > 0 && still_target(cx - 1, cy, tgt)) pend.push_back(idx - 1);
      if (still_target(cx, cy + 1, tgt)) pend.push_back(idx + GRID_W);
      if (cy > 0 && still_target(cx, cy - 1, tgt)) pend.push_back(idx - GRID_W);
    end
  endfunction

  function automatic fill_result_t predict_result(logic [OP_W-1:0] op, int unsigned x,
                                                  int unsigned y, logic [COLOR_W-1:0] tgt,
                                                  logic [COLOR_W-1:0] paint);
    fill_result_t res;
    res = '0;
    case (op)
      OP_WRITE: begin
        if (on_grid(x, y)) pixels[y * GRID_W + x] = paint;
      end
      OP_FILL: begin
        if (tgt == paint) res.fill_skipped = 1'b1;
        else flood_region(x, y, tgt, paint);
      end
      OP_READ: begin
        if (on_grid(x, y)) res.read_color = pixels[y * GRID_W + x];
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin
    fill_result_t want;
    fill_result_t got;
    if (rst_ni) begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.read_color   = rsp_mon.read_color;
        got.fill_skipped = rsp_mon.fill_skipped;
        if (result_q.size() == 0) begin
          $display("%0t: result with none expected, read_color %08h fill_skipped %0b",
                   $time, got.read_color, got.fill_skipped);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          if (got.read_color !== want.read_color) begin
            $display("%0t: read_color mismatch, expected %08h, got %08h",
                     $time, want.read_color, got.read_color);
            mismatches++;
          end
          if (got.fill_skipped !== want.fill_skipped) begin
            $display("%0t: fill_skipped mismatch, expected %0b, got %0b",
                     $time, want.fill_skipped, got.fill_skipped);
            mismatches++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        result_q.push_back(predict_result(req_mon.op, 32'(req_mon.x), 32'(req_mon.y),
                                          req_mon.target_color, req_mon.new_color));
      end
      waiting = result_q.size();
    end
  end

endmodule

>>> sim/raster_flood_fill_core_tb.sv
// ----------------------------------------------------------------------------
// raster_flood_fill_core_tb: testbench for the raster flood fill core
// Drives writes, reads, fills and unused op codes with bursty requests and a
// stalling result side. Fills run inside two walled 8x8 areas in opposite
// corners so that every pixel a fill touches has been written; elsewhere only
// writes, reads of written pixels, seed-only fills, equal-color fills and unused ops are sent.
// ----------------------------------------------------------------------------
module raster_flood_fill_core_tb;
  import rff_pkg::*;

  localparam int unsigned GRID_W         = GRID_WIDTH_DEF;
  localparam int unsigned GRID_H         = GRID_HEIGHT_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
  localparam logic [31:0] WALL_COLOR     = 32'h5AA5_C33C;
  localparam int unsigned RANDOM_ROUNDS  = 300;
  localparam int unsigned HOLD_AT        = 250;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned TAIL_CYCLES    = 50;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;

  rff_in_if  req_if ();
  rff_out_if rsp_if ();

  int unsigned sent       = 0;
  int unsigned rsp_seen   = 0;
  int unsigned burst_left = 0;
  int unsigned n_write    = 0;
  int unsigned n_read     = 0;
  int unsigned n_fill     = 0;
  int unsigned n_skip     = 0;
  int unsigned n_unused   = 0;
  int unsigned n_drain    = 0;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned painted;

  logic [31:0] stray_color [int];
  int          stray_cells [$];

  raster_flood_fill_core #(
    .GRID_WIDTH (GRID_W),
    .GRID_HEIGHT(GRID_H)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  raster_fill_checker #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H)
  ) i_fill_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_mon   (req_if),
    .rsp_mon   (rsp_if),
    .mismatch_o(mismatches),
    .pending_o (pending),
    .painted_o (painted)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready) rsp_seen <= rsp_seen + 1;
  end

  function automatic logic [31:0] pick_color();
    logic [31:0] c;
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 3))
        0:       c = 32'h0000_0000;
        1:       c = 32'hFFFF_FFFF;
        2:       c = 32'hFF00_00FF;
        default: c = 32'h00FF_00FF;
      endcase
    end else begin
      c = $urandom();
    end
    if (c == WALL_COLOR) c = c ^ 32'h1;
    return c;
  endfunction

  function automatic bit in_block(int x, int y);
    return (x <= 8 && y <= 8) || (x >= 55 && y >= 55);
  endfunction

  task automatic send_req(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] x,
                          input logic [COORD_W-1:0] y, input logic [COLOR_W-1:0] tgt,
                          input logic [COLOR_W-1:0] paint);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid        <= 1'b1;
    req_if.op           <= op;
    req_if.x            <= x;
    req_if.y            <= y;
    req_if.target_color <= tgt;
    req_if.new_color    <= paint;
    do @(negedge clk_i); while (!req_if.ready);
    @(posedge clk_i);
    sent++;
    case (op)
      OP_WRITE: n_write++;
      OP_READ:  n_read++;
      OP_FILL:  if (tgt == paint) n_skip++; else n_fill++;
      default:  n_unused++;
    endcase
  endtask

  task automatic write_px(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                          input logic [COLOR_W-1:0] c);
    int idx;
    idx = int'(y) * GRID_W + int'(x);
    send_req(OP_WRITE, x, y, $urandom(), c);
    if (!in_block(int'(x), int'(y))) begin
      if (!stray_color.exists(idx)) stray_cells.push_back(idx);
      stray_color[idx] = c;
    end
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (rsp_seen != sent);
  endtask

  // walled square: lo..lo+8, wall on row and column 'wall'
  task automatic build_area(input int lo, input int wall);
    logic [31:0] base;
    logic [31:0] c;
    base = pick_color();
    for (int y = lo; y <= lo + 8; y++) begin
      for (int x = lo; x <= lo + 8; x++) begin
        if (x == wall || y == wall) c = WALL_COLOR;
        else c = ($urandom_range(0, 3) != 0) ? base : pick_color();
        write_px(COORD_W'(x), COORD_W'(y), c);
      end
    end
  endtask

  task automatic pick_area(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
    int lo;
    lo = $urandom_range(0, 1) ? 56 : 0;
    x  = COORD_W'(lo + int'($urandom_range(0, 7)));
    y  = COORD_W'(lo + int'($urandom_range(0, 7)));
  endtask

  task automatic pick_wall(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
    int lo;
    int wall;
    int k;
    if ($urandom_range(0, 1)) begin
      lo   = 55;
      wall = 55;
    end else begin
      lo   = 0;
      wall = 8;
    end
    k = lo + int'($urandom_range(0, 8));
    if ($urandom_range(0, 1)) begin
      x = COORD_W'(wall);
      y = COORD_W'(k);
    end else begin
      x = COORD_W'(k);
      y = COORD_W'(wall);
    end
  endtask

  task automatic pick_stray(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
    int px;
    int py;
    do begin
      px = $urandom_range(0, 63);
      py = $urandom_range(0, 63);
    end while (in_block(px, py));
    x = COORD_W'(px);
    y = COORD_W'(py);
  endtask

  // result side: random stall modes, one long hold-off
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    bit          held;
    mode      = 0;
    mode_left = 0;
    held      = 1'b0;
    rsp_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && rsp_seen >= HOLD_AT) begin
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (mode)
        0:       rsp_if.ready <= 1'b1;
        1:       rsp_if.ready <= 1'($urandom_range(0, 1));
        default: rsp_if.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles, %0d requests and %0d results so far",
             $time, WATCHDOG_LIMIT, sent, rsp_seen);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [31:0]        c;
    logic [31:0]        d;
    int unsigned        roll;
    int                 idx;

    req_if.valid        = 1'b0;
    req_if.op           = OP_WRITE;
    req_if.x            = '0;
    req_if.y            = '0;
    req_if.target_color = '0;
    req_if.new_color    = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners, equal colors, seed-only fills, unused op
    write_px(0, 0, 32'h0000_0000);
    write_px(63, 63, 32'hFFFF_FFFF);
    write_px(63, 0, 32'hA5A5_A5A5);
    write_px(0, 63, 32'h1234_5678);
    send_req(OP_READ, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_READ, 63, 63, 32'h0, 32'h0);
    send_req(OP_READ, 63, 0, $urandom(), $urandom());
    send_req(OP_READ, 0, 63, $urandom(), $urandom());
    send_req(OP_FILL, 63, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_FILL, 0, 0, 32'h0, 32'h0);
    c = $urandom();
    send_req(OP_FILL, 31, 42, c, c);
    send_req(OP_FILL, 63, 0, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
    send_req(OP_READ, 63, 0, 32'h0, 32'h0);
    send_req(OP_FILL, 0, 63, 32'hEDCB_A987, 32'h0);
    send_req(OP_READ, 0, 63, 32'h0, 32'h0);
    send_req(OP_UNUSED, 63, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_UNUSED, 0, 0, 32'h0, 32'h0);
    write_px(42, 21, 32'hFFFF_FFFF);
    send_req(OP_READ, 42, 21, 32'h0, 32'h0);

    build_area(0, 8);
    build_area(55, 55);

    for (int i = 0; i < RANDOM_ROUNDS; i++) begin
      if (i % 90 == 45) begin
        wait_drained();
        n_drain++;
      end
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        pick_area(x, y);
        write_px(x, y, pick_color());
      end else if (roll < 40) begin
        pick_area(x, y);
        c = pick_color();
        write_px(x, y, c);
        do d = pick_color(); while (d == c);
        send_req(OP_FILL, x, y, c, d);
      end else if (roll < 55) begin
        pick_area(x, y);
        c = pick_color();
        d = ($urandom_range(0, 9) == 0) ? c : pick_color();
        send_req(OP_FILL, x, y, c, d);
      end else if (roll < 80) begin
        case ($urandom_range(0, 3))
          0, 1: pick_area(x, y);
          2:    pick_wall(x, y);
          default: begin
            idx = stray_cells[$urandom_range(0, stray_cells.size() - 1)];
            x   = COORD_W'(idx % GRID_W);
            y   = COORD_W'(idx / GRID_W);
          end
        endcase
        send_req(OP_READ, x, y, $urandom(), $urandom());
      end else if (roll < 88) begin
        pick_stray(x, y);
        write_px(x, y, $urandom());
      end else if (roll < 94) begin
        if ($urandom_range(0, 1)) begin
          idx = stray_cells[$urandom_range(0, stray_cells.size() - 1)];
          c   = stray_color[idx] ^ ($urandom() | 32'h1);
          send_req(OP_FILL, COORD_W'(idx % GRID_W), COORD_W'(idx / GRID_W), c, $urandom());
        end else begin
          c = $urandom();
          send_req(OP_FILL, COORD_W'($urandom_range(0, 63)), COORD_W'($urandom_range(0, 63)),
                   c, c);
        end
      end else begin
        send_req(OP_UNUSED, COORD_W'($urandom_range(0, 63)), COORD_W'($urandom_range(0, 63)),
                 $urandom(), $urandom());
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests: %0d writes, %0d reads, %0d fills, %0d equal-color fills,",
             sent, n_write, n_read, n_fill, n_skip);
    $display("%0d unused op; fills repainted %0d pixels; one %0d-cycle result hold-off, %0d drains",
             n_unused, painted, HOLD_CYCLES, n_drain);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
